[hw/rtl/aes_ccm_stream_encrypt_assert.svh]
// Assertion macros for the CCM stream encryptor.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef AES_CCM_STREAM_ENCRYPT_ASSERT_SVH
`define AES_CCM_STREAM_ENCRYPT_ASSERT_SVH

// Same-cycle implication.
`define ACCM_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define ACCM_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hw/rtl/accm_pkg.sv]
// Shared types, constants and AES helper functions for the CCM encryptor.
// No dependencies.
package accm_pkg;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;
   localparam int   AES_ROUNDS = 10;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_tag;
      logic       last;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_HDR = 2'd0,
      KIND_PAY = 2'd1,
      KIND_FIN = 2'd2,
      KIND_ERR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic       start;
      logic       last;
      logic [7:0] data_byte;
   } item_type;

   typedef enum logic [2:0] {
      REG_KEY_HIGH       = 3'd0,
      REG_KEY_LOW        = 3'd1,
      REG_NONCE_HIGH     = 3'd2,
      REG_NONCE_LOW      = 3'd3,
      REG_NONCE_LENGTH   = 3'd4,
      REG_TAG_LENGTH     = 3'd5,
      REG_HEADER_LENGTH  = 3'd6,
      REG_PAYLOAD_LENGTH = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [39:0] nonce_high;
      logic [63:0] nonce_low;
      logic [3:0]  nonce_length;
      logic [4:0]  tag_length;
      logic [15:0] header_length;
      logic [15:0] payload_length;
   } csr_type;

   typedef struct packed {
      logic       started;
      logic [1:0] fill;
   } front_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] byte_at(input logic [127:0] blk, input logic [3:0] idx);
      return blk[{~idx, 3'b000} +: 8];
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[c*4+i] = SBOX[s[127 - 8*((((c + i) & 3) * 4) + i) -: 8]];
         end
      end
      if (!last_rnd) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[c*4];
            a1 = t[c*4+1];
            a2 = t[c*4+2];
            a3 = t[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[c*4]   = a0 ^ al ^ xt(a0 ^ a1);
            t[c*4+1] = a1 ^ al ^ xt(a1 ^ a2);
            t[c*4+2] = a2 ^ al ^ xt(a2 ^ a3);
            t[c*4+3] = a3 ^ al ^ xt(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = t[i];
      end
      return r;
   endfunction

   function automatic logic [127:0] key_expand(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tmp;
      w0  = k[127:96];
      w1  = k[95:64];
      w2  = k[63:32];
      w3  = k[31:0];
      tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0  = w0 ^ tmp;
      w1  = w1 ^ w0;
      w2  = w2 ^ w1;
      w3  = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [3:0] nonce_used(input logic [3:0] len);
      return (len > 4'd13) ? 4'd13 : len;
   endfunction

   function automatic logic [4:0] tag_used(input logic [4:0] len);
      logic [4:0] t;
      t = len & 5'h1e;
      if (t < 5'd4) t = 5'd4;
      if (t > 5'd16) t = 5'd16;
      return t;
   endfunction

endpackage

[hw/rtl/accm_aes_core.sv]
// Iterative AES-128 encryption core, one round per cycle, keys expanded on the fly.
// Depends on accm_pkg.
module accm_aes_core import accm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] block_in,
   input  logic [127:0] key,
   output logic         done,
   output logic [127:0] block_out
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [3:0]   round_ff, round_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [127:0] rk_ff, rk_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] next_rk;
   logic         last_rnd;

   assign next_rk  = key_expand(rk_ff, rcon_ff);
   assign last_rnd = (round_ff == 4'(AES_ROUNDS));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      round_in = round_ff;
      rcon_in  = rcon_ff;
      rk_in    = rk_ff;
      st_in    = st_ff;
      if (start) begin
         busy_in  = 1'b1;
         round_in = 4'd1;
         rcon_in  = 8'h01;
         rk_in    = key;
         st_in    = block_in ^ key;
      end else if (busy_ff) begin
         st_in    = aes_round(st_ff, last_rnd) ^ next_rk;
         rk_in    = next_rk;
         rcon_in  = xt(rcon_ff);
         round_in = round_ff + 4'd1;
         if (last_rnd) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      round_ff <= round_in;
      rcon_ff  <= rcon_in;
      rk_ff    <= rk_in;
      st_ff    <= st_in;
   end

   assign done      = done_ff;
   assign block_out = st_ff;

endmodule

[hw/rtl/accm_front.sv]
// Front end: accepts beats, tracks frame position and classifies items into a small queue.
// Depends on accm_pkg.
module accm_front import accm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             abort,
   input  logic [15:0]      header_length,
   input  logic [15:0]      payload_length,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output item_type         item,
   output logic             item_valid,
   input  logic             pop,
   output front_status_type status
);

   item_type    queue_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  fill_ff, fill_in;
   logic        started_ff, started_in;
   logic [15:0] hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] pay_cnt_ff, pay_cnt_in;
   logic        accept;
   logic [15:0] hc, pc;
   logic [16:0] hc_nx, pc_nx;
   item_type    cls;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (fill_ff == 2'd2);
   assign hc        = started_ff ? hdr_cnt_ff : 16'd0;
   assign pc        = started_ff ? pay_cnt_ff : 16'd0;
   assign hc_nx     = {1'b0, hc} + 17'd1;
   assign pc_nx     = {1'b0, pc} + 17'd1;

   always_comb begin
      cls.start     = !started_ff;
      cls.data_byte = req_data.data_byte;
      cls.last      = 1'b0;
      cls.kind      = KIND_ERR;
      started_in    = started_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      pay_cnt_in    = pay_cnt_ff;
      if (accept) begin
         started_in = 1'b1;
         hdr_cnt_in = hc;
         pay_cnt_in = pc;
         if (req_data.opcode == OP_FINISH) begin
            if (hc == header_length && pc == payload_length) begin
               cls.kind   = KIND_FIN;
               started_in = 1'b0;
               hdr_cnt_in = 16'd0;
               pay_cnt_in = 16'd0;
            end
         end else if (hc < header_length) begin
            cls.kind   = KIND_HDR;
            cls.last   = (hc_nx == {1'b0, header_length});
            hdr_cnt_in = hc_nx[15:0];
         end else if (pc < payload_length) begin
            cls.kind   = KIND_PAY;
            cls.last   = (pc_nx == {1'b0, payload_length});
            pay_cnt_in = pc_nx[15:0];
         end
      end
      if (abort) begin
         started_in = 1'b0;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept && !pop) fill_in = fill_ff + 2'd1;
      if (!accept && pop) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         fill_ff    <= 2'd0;
         started_ff <= 1'b0;
         hdr_cnt_ff <= 16'd0;
         pay_cnt_ff <= 16'd0;
      end else begin
         if (accept) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         fill_ff    <= fill_in;
         started_ff <= started_in;
         hdr_cnt_ff <= hdr_cnt_in;
         pay_cnt_ff <= pay_cnt_in;
      end
      if (accept) queue_ff[wr_ptr_ff] <= cls;
   end

   assign item           = queue_ff[rd_ptr_ff];
   assign item_valid     = (fill_ff != 2'd0);
   assign status.started = started_ff;
   assign status.fill    = fill_ff;

endmodule

[hw/rtl/accm_back.sv]
// Back end: runs CBC-MAC and CTR on the shared AES core and drives the result register.
// Depends on accm_pkg and accm_aes_core.
module accm_back import accm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  csr_type  csr,
   input  item_type item,
   input  logic     item_valid,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_B0     = 8'b0000_0010,
      ST_WORK   = 8'b0000_0100,
      ST_ABSORB = 8'b0000_1000,
      ST_FLUSH  = 8'b0001_0000,
      ST_OUT    = 8'b0010_0000,
      ST_TAG    = 8'b0100_0000,
      ST_WAIT   = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   state_type    ret_ff, ret_in;
   state_type    after_mac;
   logic         dest_pad_ff, dest_pad_in;
   item_type     itm_ff, itm_in;
   logic [127:0] mac_ff, mac_in;
   logic [127:0] ctr_ff, ctr_in;
   logic [127:0] pad_ff, pad_in;
   logic [4:0]   pad_idx_ff, pad_idx_in;
   logic [4:0]   fill_ff, fill_in;
   logic [3:0]   tag_idx_ff, tag_idx_in;
   rsp_type      res_ff, res_in;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;
   logic         emit;
   rsp_type      emit_data;
   logic         aes_start, aes_done;
   logic [127:0] aes_in, aes_out;

   logic [3:0]   n_used, l_minus1;
   logic [4:0]   t_used, t_half;
   logic [127:0] mask, nonce_part, b0, ctr0, ctr_inc, henc;
   logic [4:0]   hfill;
   logic [7:0]   flags;
   logic         out_free, tag_last;

   accm_aes_core u_aes (
      .clock     (clock),
      .reset     (reset),
      .start     (aes_start),
      .block_in  (aes_in),
      .key       ({csr.key_high, csr.key_low}),
      .done      (aes_done),
      .block_out (aes_out)
   );

   assign n_used     = nonce_used(csr.nonce_length);
   assign l_minus1   = 4'd14 - n_used;
   assign t_used     = tag_used(csr.tag_length);
   assign t_half     = (t_used - 5'd2) >> 1;
   assign mask       = ~({128{1'b1}} << {(l_minus1 + 4'd1), 3'b000});
   assign nonce_part = {8'h00, csr.nonce_high, csr.nonce_low, 16'h0000} & ~mask;
   assign flags      = ((csr.header_length != 16'd0) ? 8'h40 : 8'h00)
                       | {2'b00, t_half[2:0], 3'b000} | {4'h0, l_minus1};
   assign b0         = nonce_part | {flags, 104'h0, csr.payload_length};
   assign ctr0       = nonce_part | {4'h0, l_minus1, 120'h0};
   assign ctr_inc    = (ctr_ff & ~mask) | ((ctr_ff + 128'd1) & mask);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign tag_last   = ({1'b0, tag_idx_ff} == (t_used - 5'd1));
   assign after_mac  = (itm_ff.kind == KIND_PAY) ? ST_OUT : ST_IDLE;

   always_comb begin
      if (csr.header_length == 16'd0) begin
         henc  = '0;
         hfill = 5'd0;
      end else if (csr.header_length < 16'hff00) begin
         henc  = {csr.header_length, 112'h0};
         hfill = 5'd2;
      end else begin
         henc  = {16'hfffe, 16'h0000, csr.header_length, 80'h0};
         hfill = 5'd6;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      dest_pad_in = dest_pad_ff;
      itm_in      = itm_ff;
      mac_in      = mac_ff;
      ctr_in      = ctr_ff;
      pad_in      = pad_ff;
      pad_idx_in  = pad_idx_ff;
      fill_in     = fill_ff;
      tag_idx_in  = tag_idx_ff;
      res_in      = res_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      emit_data   = '0;
      aes_start   = 1'b0;
      aes_in      = mac_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               pop    = 1'b1;
               itm_in = item;
               if (item.start) begin
                  ctr_in      = ctr0;
                  aes_start   = 1'b1;
                  aes_in      = b0;
                  dest_pad_in = 1'b0;
                  ret_in      = ST_B0;
                  state_in    = ST_WAIT;
               end else begin
                  state_in = ST_WORK;
               end
            end
         end
         ST_B0: begin
            mac_in     = mac_ff ^ henc;
            fill_in    = hfill;
            pad_idx_in = 5'd16;
            state_in   = ST_WORK;
         end
         ST_WORK: begin
            case (itm_ff.kind)
               KIND_HDR: state_in = ST_ABSORB;
               KIND_PAY: begin
                  if (pad_idx_ff[4]) begin
                     ctr_in      = ctr_inc;
                     aes_start   = 1'b1;
                     aes_in      = ctr_inc;
                     dest_pad_in = 1'b1;
                     ret_in      = ST_WORK;
                     state_in    = ST_WAIT;
                  end else begin
                     res_in.out_byte = byte_at(pad_ff, pad_idx_ff[3:0]) ^ itm_ff.data_byte;
                     res_in.is_tag   = 1'b0;
                     res_in.last     = itm_ff.last;
                     res_in.error    = 1'b0;
                     pad_idx_in      = pad_idx_ff + 5'd1;
                     if (itm_ff.last) ctr_in = ctr_ff & ~mask;
                     state_in = ST_ABSORB;
                  end
               end
               KIND_FIN: begin
                  aes_start   = 1'b1;
                  aes_in      = ctr_ff;
                  dest_pad_in = 1'b1;
                  ret_in      = ST_TAG;
                  tag_idx_in  = 4'd0;
                  state_in    = ST_WAIT;
               end
               default: begin
                  res_in.out_byte = 8'h00;
                  res_in.is_tag   = 1'b0;
                  res_in.last     = 1'b1;
                  res_in.error    = 1'b1;
                  state_in        = ST_OUT;
               end
            endcase
         end
         ST_ABSORB: begin
            if (fill_ff[4]) begin
               aes_start   = 1'b1;
               aes_in      = mac_ff;
               dest_pad_in = 1'b0;
               ret_in      = ST_ABSORB;
               state_in    = ST_WAIT;
            end else begin
               mac_in   = mac_ff ^ ({itm_ff.data_byte, 120'h0} >> {fill_ff[3:0], 3'b000});
               fill_in  = fill_ff + 5'd1;
               state_in = itm_ff.last ? ST_FLUSH : after_mac;
            end
         end
         ST_FLUSH: begin
            if (fill_ff != 5'd0) begin
               aes_start   = 1'b1;
               aes_in      = mac_ff;
               dest_pad_in = 1'b0;
               ret_in      = after_mac;
               state_in    = ST_WAIT;
            end else begin
               state_in = after_mac;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = res_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_TAG: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_byte = byte_at(mac_ff ^ pad_ff, tag_idx_ff);
               emit_data.is_tag   = 1'b1;
               emit_data.last     = tag_last;
               emit_data.error    = 1'b0;
               tag_idx_in         = tag_idx_ff + 4'd1;
               if (tag_last) begin
                  fill_in    = 5'd0;
                  pad_idx_in = 5'd16;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_WAIT: begin
            if (aes_done) begin
               if (dest_pad_ff) begin
                  pad_in     = aes_out;
                  pad_idx_in = 5'd0;
               end else begin
                  mac_in  = aes_out;
                  fill_in = 5'd0;
               end
               state_in = ret_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mac_ff       <= '0;
         ctr_ff       <= '0;
         pad_ff       <= '0;
         pad_idx_ff   <= 5'd16;
         fill_ff      <= 5'd0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         mac_ff     <= mac_in;
         ctr_ff     <= ctr_in;
         pad_ff     <= pad_in;
         pad_idx_ff <= pad_idx_in;
         fill_ff    <= fill_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      dest_pad_ff <= dest_pad_in;
      itm_ff      <= itm_in;
      tag_idx_ff  <= tag_idx_in;
      res_ff      <= res_in;
      if (emit) rsp_data_ff <= emit_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/aes_ccm_stream_encrypt.sv]
// AES-128 CCM stream encryptor: usage and top-level wiring.
// Depends on accm_pkg, accm_front, accm_back and the assertion macro header.
//
// Frame parameters are to be written over the APB port only while the block is idle;
// the block does not enforce this, and any write aborts the current frame. Data beats
// carry header bytes first, then plaintext bytes; a finish beat after the last byte
// returns the tag, and a beat out of place returns an error. The front end queues up
// to two beats while the back end works, and a result register lets the next beat be
// taken while a result waits. All AES work runs on one iterative core at one round per
// cycle: a block for B0 on the first beat of a frame, one for each new keystream block,
// each full MAC block and the MAC flush after the last header or payload byte, and one
// for the tag pad on a finish beat, after which the tag bytes are returned in order.
`include "aes_ccm_stream_encrypt_assert.svh"
module aes_ccm_stream_encrypt import accm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   csr_type          csr_ff;
   logic             cfg_write;
   reg_index_type    reg_idx;
   item_type         item;
   logic             item_valid, pop;
   front_status_type fe_status;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.key_high       <= '0;
         csr_ff.key_low        <= '0;
         csr_ff.nonce_high     <= '0;
         csr_ff.nonce_low      <= '0;
         csr_ff.nonce_length   <= 4'd13;
         csr_ff.tag_length     <= 5'd8;
         csr_ff.header_length  <= '0;
         csr_ff.payload_length <= '0;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_KEY_HIGH:       csr_ff.key_high       <= csr_pwdata;
            REG_KEY_LOW:        csr_ff.key_low        <= csr_pwdata;
            REG_NONCE_HIGH:     csr_ff.nonce_high     <= csr_pwdata[39:0];
            REG_NONCE_LOW:      csr_ff.nonce_low      <= csr_pwdata;
            REG_NONCE_LENGTH:   csr_ff.nonce_length   <= csr_pwdata[3:0];
            REG_TAG_LENGTH:     csr_ff.tag_length     <= csr_pwdata[4:0];
            REG_HEADER_LENGTH:  csr_ff.header_length  <= csr_pwdata[15:0];
            REG_PAYLOAD_LENGTH: csr_ff.payload_length <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY_HIGH:       csr_prdata = csr_ff.key_high;
         REG_KEY_LOW:        csr_prdata = csr_ff.key_low;
         REG_NONCE_HIGH:     csr_prdata = {24'h0, csr_ff.nonce_high};
         REG_NONCE_LOW:      csr_prdata = csr_ff.nonce_low;
         REG_NONCE_LENGTH:   csr_prdata = {60'h0, csr_ff.nonce_length};
         REG_TAG_LENGTH:     csr_prdata = {59'h0, csr_ff.tag_length};
         REG_HEADER_LENGTH:  csr_prdata = {48'h0, csr_ff.header_length};
         REG_PAYLOAD_LENGTH: csr_prdata = {48'h0, csr_ff.payload_length};
         default:            csr_prdata = '0;
      endcase
   end

   accm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .abort          (cfg_write),
      .header_length  (csr_ff.header_length),
      .payload_length (csr_ff.payload_length),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .item           (item),
      .item_valid     (item_valid),
      .pop            (pop),
      .status         (fe_status)
   );

   accm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .item       (item),
      .item_valid (item_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   `ACCM_ASSERT_NEXT(a_cfg_abort, cfg_write, !fe_status.started, "frame not aborted by write")
   `ACCM_ASSERT_NOW(a_pop_nonempty, pop, fe_status.fill != 2'd0, "pop from empty queue")
   `ACCM_ASSERT_NOW(a_tag_clean, rsp_valid && rsp_data.is_tag, !rsp_data.error, "tag with error")

endmodule
